// ----- sv/dpc_pkg.sv -----
// Shared types and constants for the disparity to point cloud block.
// Used by every module of the block but dpc_sqrt; depends on nothing.
`default_nettype none

package dpc_pkg;

    // Default sizes of the line buffer and row counter
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;

    // Saturation limit of a coordinate and the 0.01 norm floor in Q.16
    localparam logic [30:0] SAT31     = 31'h7FFF_FFFF;
    localparam logic [9:0]  FLOOR_Q16 = 10'd655;

    // Shared divider geometry
    localparam int unsigned DIV_NW = 48;
    localparam int unsigned DIV_DW = 32;
    localparam int unsigned DIV_CW = 6;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX_DISP     = 3'd2;
    localparam logic [2:0] REG_DISP_OFFSET  = 3'd3;
    localparam logic [2:0] REG_FOCAL        = 3'd4;
    localparam logic [2:0] REG_BASELINE     = 3'd5;

    typedef struct packed {
        logic [11:0] image_width;
        logic [12:0] image_height;
        logic [11:0] max_disparity;
        logic [12:0] disparity_offset;
        logic [15:0] focal_length;
        logic [15:0] baseline;
    } dpc_cfg_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_A,
        OP_CAP_A,
        OP_CAP_R,
        OP_CMUL,
        OP_CDIV,
        OP_CSTORE,
        OP_DIFF,
        OP_XMUL,
        OP_XACC,
        OP_TSHIFT,
        OP_SMUL,
        OP_SACC,
        OP_SQRT,
        OP_DEN,
        OP_NDIV,
        OP_NSTORE,
        OP_EMIT1,
        OP_EMIT2,
        OP_WRITE
    } dpc_op_t;

    typedef struct packed {
        dpc_op_t    op;
        logic [2:0] idx;
    } dpc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic has_above;
        logic emit_second;
        logic t_more;
        logic out_free;
    } dpc_status_t;

    typedef struct packed {
        logic [10:0]        column;
        logic [11:0]        row_index;
        logic [30:0]        point_x;
        logic [30:0]        point_y;
        logic [30:0]        point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } dpc_result_t;

endpackage

`default_nettype wire

// ----- sv/dpc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dpc_pkg for its widths.
`default_nettype none

module dpc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dpc_pkg::DIV_NW-1:0] num,
    input  logic [dpc_pkg::DIV_DW-1:0] den,
    output logic                       busy,
    output logic [dpc_pkg::DIV_NW-1:0] quot
);
    import dpc_pkg::*;

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              take;

    // One trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIV_NW-1]};
        diff    = shifted - {1'b0, den_reg};
        take    = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CW'(DIV_NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Payload: remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= den;
            quot_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            quot_reg <= {quot_reg[DIV_NW-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- sv/dpc_sqrt.sv -----
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// Stand-alone unit; no package items needed.
`default_nettype none

module dpc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);
    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        take;

    // Bring down two bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg[32:0], rad_reg[63:62]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- sv/dpc_datapath.sv -----
// Datapath: line buffer, shared multiplier, divider and square root unit,
// point and normal registers, pixel counters and the result register.
// Depends on dpc_pkg, dpc_div and dpc_sqrt.
`default_nettype none

module dpc_datapath #(
    parameter int unsigned MAX_WIDTH  = dpc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = dpc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpc_pkg::dpc_cfg_t    cfg,
    input  dpc_pkg::dpc_cmd_t    cmd,
    output dpc_pkg::dpc_status_t status,
    input  logic [12:0]          in_disparity,
    input  logic                 in_pixel_valid,
    input  logic [7:0]           in_red,
    input  logic [7:0]           in_green,
    input  logic [7:0]           in_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dpc_pkg::dpc_result_t out_result
);
    import dpc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW = 3 * 31 + 24 + 1;

    // Pixel counters and per-item registers
    logic [CW-1:0]      col_cnt_reg;
    logic [RW-1:0]      row_cnt_reg;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [13:0]        d16_reg;
    logic [23:0]        color_reg;
    logic               valid_in_reg;
    logic               emit_second_reg;
    logic               has_above_reg;
    logic [30:0]        a_reg [3];
    logic [30:0]        r_reg [3];
    logic [23:0]        a_color_reg;
    logic [30:0]        p_reg [3];
    logic               num_zero_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] u_reg [3];
    logic signed [31:0] v_reg [3];
    logic               s_reg;
    logic signed [63:0] tmp_reg;
    logic [60:0]        wmag_reg [3];
    logic               wneg_reg [3];
    logic [4:0]         t_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        den_reg;
    logic signed [15:0] n_reg [3];
    logic               out_valid_reg;
    dpc_result_t        out_res_reg;

    // Line buffer
    logic [MW-1:0]      line_mem [MAX_WIDTH];
    logic [MW-1:0]      rdata_reg;
    logic [CW-1:0]      rd_addr;
    logic [MW-1:0]      wr_word;

    logic [31:0]        w_eff;
    logic [31:0]        h_eff;
    logic [31:0]        col_plus;
    logic [31:0]        row_plus;
    logic [31:0]        row_cnt_plus;
    logic [11:0]        dcl;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_busy;
    logic [DIV_NW-1:0]  div_quot;
    logic               sqrt_busy;
    logic [31:0]        sqrt_root;
    logic signed [31:0] du [3];
    logic signed [31:0] dv [3];
    logic [30:0]        du_mag [3];
    logic [30:0]        dv_mag [3];
    logic signed [31:0] u_new [3];
    logic signed [31:0] v_new [3];
    logic               s_any;
    logic signed [63:0] xdiff;
    logic [63:0]        xmag;
    logic               t_more;
    logic [60:0]        wmag_sel;
    logic               wneg_sel;
    logic [5:0]         fl_sh;
    logic [31:0]        fl;
    logic [31:0]        den_new;
    logic [15:0]        q16;
    logic [31:0]        col32;
    logic [31:0]        row32;
    logic [31:0]        row_m1_32;
    logic               out_free;

    // Effective sizes after clamping
    always_comb
    begin
        w_eff = 32'(cfg.image_width);
        if (w_eff == 32'd0)
        begin
            w_eff = 32'd1;
        end
        else if (w_eff > 32'(MAX_WIDTH))
        begin
            w_eff = 32'(MAX_WIDTH);
        end
        h_eff = 32'(cfg.image_height);
        if (h_eff == 32'd0)
        begin
            h_eff = 32'd1;
        end
        else if (h_eff > 32'(MAX_HEIGHT))
        begin
            h_eff = 32'(MAX_HEIGHT);
        end
    end

    assign col_plus     = 32'(col_reg) + 32'd1;
    assign row_plus     = 32'(row_reg) + 32'd1;
    assign row_cnt_plus = 32'(row_cnt_reg) + 32'd1;
    assign col32        = 32'(col_reg);
    assign row32        = 32'(row_reg);
    assign row_m1_32    = row32 - 32'd1;

    // Disparity clamp
    always_comb
    begin
        if (in_disparity[12])
        begin
            dcl = '0;
        end
        else if (in_disparity[11:0] > cfg.max_disparity)
        begin
            dcl = cfg.max_disparity;
        end
        else
        begin
            dcl = in_disparity[11:0];
        end
    end

    // Line buffer ports
    assign rd_addr = (cmd.op == OP_CAP_A) ? col_plus[CW-1:0] : col_reg;
    assign wr_word = {valid_in_reg, color_reg, p_reg[2], p_reg[1], p_reg[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
        begin
            line_mem[col_reg] <= wr_word;
        end
        rdata_reg <= line_mem[rd_addr];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_CMUL:
            begin
                mul_b = $signed(32'(cfg.baseline));
                case (cmd.idx)
                    3'd0:    mul_a = $signed(32'(col_reg));
                    3'd1:    mul_a = $signed(32'(row_reg));
                    default: mul_a = $signed(32'(cfg.focal_length));
                endcase
            end
            OP_XMUL:
            begin
                case (cmd.idx)
                    3'd0:    begin mul_a = u_reg[1]; mul_b = v_reg[2]; end
                    3'd1:    begin mul_a = u_reg[2]; mul_b = v_reg[1]; end
                    3'd2:    begin mul_a = u_reg[2]; mul_b = v_reg[0]; end
                    3'd3:    begin mul_a = u_reg[0]; mul_b = v_reg[2]; end
                    3'd4:    begin mul_a = u_reg[0]; mul_b = v_reg[1]; end
                    default: begin mul_a = u_reg[1]; mul_b = v_reg[0]; end
                endcase
            end
            OP_SMUL:
            begin
                mul_a = $signed({1'b0, wmag_sel[30:0]});
                mul_b = $signed({1'b0, wmag_sel[30:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Differences to the neighbours, prescaled below 2^30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            du[i]     = $signed({1'b0, p_reg[i]}) - $signed({1'b0, a_reg[i]});
            dv[i]     = $signed({1'b0, r_reg[i]}) - $signed({1'b0, a_reg[i]});
            du_mag[i] = du[i][31] ? 31'(-du[i]) : du[i][30:0];
            dv_mag[i] = dv[i][31] ? 31'(-dv[i]) : dv[i][30:0];
        end
        s_any = du_mag[0][30] | du_mag[1][30] | du_mag[2][30]
              | dv_mag[0][30] | dv_mag[1][30] | dv_mag[2][30];
        for (int i = 0; i < 3; i++)
        begin
            u_new[i] = $signed({1'b0, (s_any ? (du_mag[i] >> 1) : du_mag[i])});
            v_new[i] = $signed({1'b0, (s_any ? (dv_mag[i] >> 1) : dv_mag[i])});
            if (du[i][31])
            begin
                u_new[i] = -u_new[i];
            end
            if (dv[i][31])
            begin
                v_new[i] = -v_new[i];
            end
        end
    end

    // Cross product term, shift test, norm floor
    always_comb
    begin
        xdiff    = tmp_reg - prod_reg;
        xmag     = xdiff[63] ? 64'(-xdiff) : 64'(xdiff);
        t_more   = (|wmag_reg[0][60:31]) | (|wmag_reg[1][60:31]) | (|wmag_reg[2][60:31]);
        wmag_sel = wmag_reg[cmd.idx[1:0]];
        wneg_sel = wneg_reg[cmd.idx[1:0]];
        fl_sh    = 6'({s_reg, 1'b0}) + 6'(t_reg);
        fl       = 32'(FLOOR_Q16) >> fl_sh;
        den_new  = sqrt_root;
        if (fl > den_new)
        begin
            den_new = fl;
        end
        if (den_new == 32'd0)
        begin
            den_new = 32'd1;
        end
        q16 = div_quot[15:0];
    end

    // Shared divider and square root
    assign div_start = (cmd.op == OP_CDIV) || (cmd.op == OP_NDIV);
    assign div_num   = (cmd.op == OP_NDIV) ? DIV_NW'({wmag_sel[30:0], 14'b0})
                                           : {prod_reg[35:0], 12'b0};
    assign div_den   = (cmd.op == OP_NDIV) ? den_reg : DIV_DW'(d16_reg);

    dpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    dpc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQRT),
        .radicand (sum_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Counters: control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cmd.op == OP_WRITE)
        begin
            if (col_plus >= w_eff)
            begin
                col_cnt_reg <= '0;
                if (row_plus >= h_eff)
                begin
                    row_cnt_reg <= '0;
                end
                else
                begin
                    row_cnt_reg <= row_plus[RW-1:0];
                end
            end
            else
            begin
                col_cnt_reg <= col_plus[CW-1:0];
            end
        end
    end

    // Result register valid flag
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.op == OP_EMIT1) || (cmd.op == OP_EMIT2))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                col_reg         <= col_cnt_reg;
                row_reg         <= row_cnt_reg;
                d16_reg         <= 14'(dcl) + 14'(cfg.disparity_offset);
                color_reg       <= {in_red, in_green, in_blue};
                valid_in_reg    <= in_pixel_valid;
                emit_second_reg <= (row_cnt_plus >= h_eff) && in_pixel_valid;
            end
            OP_CAP_A:
            begin
                a_reg[0]      <= rdata_reg[30:0];
                a_reg[1]      <= rdata_reg[61:31];
                a_reg[2]      <= rdata_reg[92:62];
                a_color_reg   <= rdata_reg[116:93];
                has_above_reg <= (row_reg != '0) && rdata_reg[117];
            end
            OP_CAP_R:
            begin
                if (col_plus < w_eff)
                begin
                    r_reg[0] <= rdata_reg[30:0];
                    r_reg[1] <= rdata_reg[61:31];
                    r_reg[2] <= rdata_reg[92:62];
                end
                else
                begin
                    r_reg[0] <= a_reg[0];
                    r_reg[1] <= a_reg[1];
                    r_reg[2] <= a_reg[2];
                end
            end
            OP_CDIV:
            begin
                num_zero_reg <= (prod_reg == '0);
            end
            OP_CSTORE:
            begin
                if (num_zero_reg)
                begin
                    p_reg[cmd.idx[1:0]] <= '0;
                end
                else if (div_quot > DIV_NW'(SAT31))
                begin
                    p_reg[cmd.idx[1:0]] <= SAT31;
                end
                else
                begin
                    p_reg[cmd.idx[1:0]] <= div_quot[30:0];
                end
            end
            OP_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    u_reg[i] <= u_new[i];
                    v_reg[i] <= v_new[i];
                end
                s_reg   <= s_any;
                t_reg   <= '0;
                sum_reg <= '0;
            end
            OP_XACC:
            begin
                if (!cmd.idx[0])
                begin
                    tmp_reg <= prod_reg;
                end
                else
                begin
                    wneg_reg[cmd.idx[2:1]] <= xdiff[63];
                    wmag_reg[cmd.idx[2:1]] <= xmag[60:0];
                end
            end
            OP_TSHIFT:
            begin
                if (t_more)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        wmag_reg[i] <= wmag_reg[i] >> 1;
                    end
                    t_reg <= t_reg + 1'b1;
                end
            end
            OP_SACC:
            begin
                sum_reg <= sum_reg + 64'(prod_reg);
            end
            OP_DEN:
            begin
                den_reg <= den_new;
            end
            OP_NSTORE:
            begin
                n_reg[cmd.idx[1:0]] <= wneg_sel ? -$signed(q16) : $signed(q16);
            end
            OP_EMIT1:
            begin
                out_res_reg.column    <= col32[10:0];
                out_res_reg.row_index <= row_m1_32[11:0];
                out_res_reg.point_x   <= a_reg[0];
                out_res_reg.point_y   <= a_reg[1];
                out_res_reg.point_z   <= a_reg[2];
                out_res_reg.normal_x  <= n_reg[0];
                out_res_reg.normal_y  <= n_reg[1];
                out_res_reg.normal_z  <= n_reg[2];
                out_res_reg.red       <= a_color_reg[23:16];
                out_res_reg.green     <= a_color_reg[15:8];
                out_res_reg.blue      <= a_color_reg[7:0];
                out_res_reg.last      <= !emit_second_reg;
            end
            OP_EMIT2:
            begin
                out_res_reg.column    <= col32[10:0];
                out_res_reg.row_index <= row32[11:0];
                out_res_reg.point_x   <= p_reg[0];
                out_res_reg.point_y   <= p_reg[1];
                out_res_reg.point_z   <= p_reg[2];
                out_res_reg.normal_x  <= '0;
                out_res_reg.normal_y  <= '0;
                out_res_reg.normal_z  <= '0;
                out_res_reg.red       <= color_reg[23:16];
                out_res_reg.green     <= color_reg[15:8];
                out_res_reg.blue      <= color_reg[7:0];
                out_res_reg.last      <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_busy    = div_busy;
    assign status.sqrt_busy   = sqrt_busy;
    assign status.has_above   = has_above_reg;
    assign status.emit_second = emit_second_reg;
    assign status.t_more      = t_more;
    assign status.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

endmodule

`default_nettype wire

// ----- sv/dpc_ctrl.sv -----
// Controller: sequences one pixel through the datapath operations.
// Depends on dpc_pkg for command and status types.
`default_nettype none

module dpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dpc_pkg::dpc_status_t status,
    output dpc_pkg::dpc_cmd_t    cmd
);
    import dpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDA,
        S_CAPA,
        S_CAPR,
        S_CMUL,
        S_CDIV,
        S_CWAIT,
        S_CSTORE,
        S_DIFF,
        S_XMUL,
        S_XACC,
        S_TSH,
        S_SMUL,
        S_SACC,
        S_SQRT,
        S_SWAIT,
        S_DEN,
        S_NDIV,
        S_NWAIT,
        S_NSTORE,
        S_EMIT1,
        S_EMIT2,
        S_WRITE
    } state_t;

    state_t     state_reg;
    logic [2:0] idx_reg;

    // State and index counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_RDA;
                S_RDA:    state_reg <= S_CAPA;
                S_CAPA:   state_reg <= S_CAPR;
                S_CAPR:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_CMUL;
                end
                S_CMUL:   state_reg <= S_CDIV;
                S_CDIV:   state_reg <= S_CWAIT;
                S_CWAIT:  if (!status.div_busy) state_reg <= S_CSTORE;
                S_CSTORE:
                begin
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg <= '0;
                        if (status.has_above)
                        begin
                            state_reg <= S_DIFF;
                        end
                        else if (status.emit_second)
                        begin
                            state_reg <= S_EMIT2;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CMUL;
                    end
                end
                S_DIFF:   state_reg <= S_XMUL;
                S_XMUL:   state_reg <= S_XACC;
                S_XACC:
                begin
                    if (idx_reg == 3'd5)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_TSH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_XMUL;
                    end
                end
                S_TSH:    if (!status.t_more) state_reg <= S_SMUL;
                S_SMUL:   state_reg <= S_SACC;
                S_SACC:
                begin
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SMUL;
                    end
                end
                S_SQRT:   state_reg <= S_SWAIT;
                S_SWAIT:  if (!status.sqrt_busy) state_reg <= S_DEN;
                S_DEN:    state_reg <= S_NDIV;
                S_NDIV:   state_reg <= S_NWAIT;
                S_NWAIT:  if (!status.div_busy) state_reg <= S_NSTORE;
                S_NSTORE:
                begin
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_NDIV;
                    end
                end
                S_EMIT1:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= status.emit_second ? S_EMIT2 : S_WRITE;
                    end
                end
                S_EMIT2:  if (status.out_free) state_reg <= S_WRITE;
                S_WRITE:  state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Operation decode
    always_comb
    begin
        cmd.idx = idx_reg;
        case (state_reg)
            S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_RDA:    cmd.op = OP_RD_A;
            S_CAPA:   cmd.op = OP_CAP_A;
            S_CAPR:   cmd.op = OP_CAP_R;
            S_CMUL:   cmd.op = OP_CMUL;
            S_CDIV:   cmd.op = OP_CDIV;
            S_CSTORE: cmd.op = OP_CSTORE;
            S_DIFF:   cmd.op = OP_DIFF;
            S_XMUL:   cmd.op = OP_XMUL;
            S_XACC:   cmd.op = OP_XACC;
            S_TSH:    cmd.op = OP_TSHIFT;
            S_SMUL:   cmd.op = OP_SMUL;
            S_SACC:   cmd.op = OP_SACC;
            S_SQRT:   cmd.op = OP_SQRT;
            S_DEN:    cmd.op = OP_DEN;
            S_NDIV:   cmd.op = OP_NDIV;
            S_NSTORE: cmd.op = OP_NSTORE;
            S_EMIT1:  cmd.op = status.out_free ? OP_EMIT1 : OP_NONE;
            S_EMIT2:  cmd.op = status.out_free ? OP_EMIT2 : OP_NONE;
            S_WRITE:  cmd.op = OP_WRITE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ----- sv/disparity_to_point_cloud_normals.sv -----
// Top level: configuration registers, stream packing, controller and datapath.
// Depends on dpc_pkg, dpc_ctrl and dpc_datapath.
//
//  channel   direction  transfer when          payload
//  s_*       in         s_tvalid & s_tready    tdata: disparity, r, g, b; tuser: pixel_valid
//  m_*       out        m_tvalid & m_tready    tdata: point and normal; tlast: run_last
//  APB       in         psel&penable&pwrite    six registers at 4*i
//
// A pixel with a normal takes longer than one with no point above it; the shared
// 48-step divider (three divisions, three more for a normal) sets the pace.
// Input is taken only between pixels; a result waiting in the output register
// does not stop the next pixel, but a second result waits for it to be taken.
// Reset clears counters and valid flags and sets config defaults, not the line buffer.
`default_nettype none

module disparity_to_point_cloud_normals #(
    parameter int unsigned MAX_WIDTH  = dpc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = dpc_pkg::DEF_MAX_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [12:0] disparity, [20:13] red_in, [28:21] green_in, [36:29] blue_in
    input  logic [39:0]  s_tdata,
    // [0] pixel_valid
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [10:0] column, [22:11] row_index, [53:23] point_x, [84:54] point_y,
    // [115:85] point_z, [131:116] normal_x, [147:132] normal_y,
    // [163:148] normal_z, [171:164] red_out, [179:172] green_out, [187:180] blue_out
    output logic [191:0] m_tdata,
    output logic         m_tlast
);
    import dpc_pkg::*;

    dpc_cfg_t    cfg_reg;
    dpc_cmd_t    cmd;
    dpc_status_t status;
    dpc_result_t result;
    logic        out_valid;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= 12'd640;
            cfg_reg.image_height     <= 13'd480;
            cfg_reg.max_disparity    <= 12'd1264;
            cfg_reg.disparity_offset <= 13'd4320;
            cfg_reg.focal_length     <= 16'd3740;
            cfg_reg.baseline         <= 16'd160;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width      <= pwdata[11:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height     <= pwdata[12:0];
                REG_MAX_DISP:     cfg_reg.max_disparity    <= pwdata[11:0];
                REG_DISP_OFFSET:  cfg_reg.disparity_offset <= pwdata[12:0];
                REG_FOCAL:        cfg_reg.focal_length     <= pwdata[15:0];
                REG_BASELINE:     cfg_reg.baseline         <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            REG_MAX_DISP:     prdata = 32'(cfg_reg.max_disparity);
            REG_DISP_OFFSET:  prdata = 32'(cfg_reg.disparity_offset);
            REG_FOCAL:        prdata = 32'(cfg_reg.focal_length);
            REG_BASELINE:     prdata = 32'(cfg_reg.baseline);
            default:          prdata = '0;
        endcase
    end

    dpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dpc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .in_disparity   (s_tdata[12:0]),
        .in_pixel_valid (s_tuser),
        .in_red         (s_tdata[20:13]),
        .in_green       (s_tdata[28:21]),
        .in_blue        (s_tdata[36:29]),
        .out_valid      (out_valid),
        .out_ready      (m_tready),
        .out_result     (result)
    );

    // Result packing
    assign m_tvalid = out_valid;
    assign m_tlast  = result.last;
    assign m_tdata  = {4'b0, result.blue, result.green, result.red,
                       result.normal_z, result.normal_y, result.normal_x,
                       result.point_z, result.point_y, result.point_x,
                       result.row_index, result.column};

endmodule

`default_nettype wire
